// ----- rtl/core/wmd_pkg.sv -----
// Shared types, constants and the band table for the weight motion detector.
// No dependencies; every other file in rtl/core imports this package.
package wmd_pkg;

    // Fixed field widths
    localparam int SAMPLE_W   = 32;
    localparam int CFG_SEL_W  = 3;
    localparam int CFG_DIV_W  = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_ADDR_W = 1;
    localparam int BAND_W     = 7;

    // Parameter defaults
    localparam int WINDOW_DEF      = 10;
    localparam int BREAK_COUNT_DEF = 1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_SEL = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_DIV_SIZE = 1'b1;

    // Band select codes with special meaning
    localparam logic [CFG_SEL_W-1:0] SEL_BYPASS    = 3'd0;
    localparam logic [CFG_SEL_W-1:0] SEL_FROZEN_LO = 3'd6;
    localparam logic [CFG_SEL_W-1:0] SEL_FROZEN_HI = 3'd7;

    // Per-cell control: parallel fill or shift from the neighbor
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DECIDE,
        S_OUT
    } t_state;

    // Band in sixteenths of a division: 0, 0.5, 1, 2, 4, 6 divisions
    function automatic logic [BAND_W-1:0] band16(input logic [CFG_SEL_W-1:0] sel);
        logic [BAND_W-1:0] v;
        case (sel)
            3'd1:    v = 7'd8;
            3'd2:    v = 7'd16;
            3'd3:    v = 7'd32;
            3'd4:    v = 7'd64;
            3'd5:    v = 7'd96;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/weight_motion_detector.sv -----
// Weight motion detector top level: window cell row, scan, divider, decision.
// Each word is scanned, averaged and decided on, then loaded into the output register;
// bypass words go straight to the output register; frozen words give no result.
// One word at a time: a new word is taken only once the last has been loaded into
// the output register, after the cell row rotation and the divider for a scanned word.
// Reset (synchronous, active low) clears sequencer, lock, flags, registers; cells fill.
module weight_motion_detector import wmd_pkg::*; #(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int BREAK_COUNT = BREAK_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] weight_sample
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [SAMPLE_W-1:0]   m_axis_tdata,   // [31:0] settled_weight
    output logic [0:0]            m_axis_tuser,   // [0] is_stable
    // Configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int SUMW = SAMPLE_W + $clog2(WINDOW);
    localparam int CNTW = $clog2(WINDOW);
    localparam int AW   = (BREAK_COUNT < 1) ? 1 : $clog2(BREAK_COUNT + 1);
    localparam logic [AW-1:0] ALLOW_FULL = AW'(BREAK_COUNT);
    localparam int DW   = SAMPLE_W + 1;

    t_state r_state, n_state;

    logic [CFG_SEL_W-1:0]       r_band_sel;
    logic [CFG_DIV_W-1:0]       r_div_size;
    logic                       r_primed;
    logic                       r_stable, n_stable;
    logic signed [SAMPLE_W-1:0] r_lock, n_lock;
    logic [AW-1:0]              r_rise, n_rise;
    logic [AW-1:0]              r_fall, n_fall;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [CNTW-1:0]            r_scan_cnt;
    logic signed [SUMW-1:0]     r_sum;
    logic signed [SAMPLE_W-1:0] r_max, r_min;
    logic [SAMPLE_W-1:0]        r_res_data, n_res_data;
    logic                       r_res_stable;
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_out_data;
    logic                       r_out_stable;

    logic                       w_accept;
    logic                       w_bypass, w_frozen;
    t_cell_ctrl                 w_cell_ctrl;
    logic                       w_scan_en, w_div_start, w_commit, w_out_load;
    logic signed [SAMPLE_W-1:0] w_cell_q [WINDOW];
    logic signed [SAMPLE_W-1:0] w_head, w_tail;
    logic                       w_div_done;
    logic signed [SAMPLE_W-1:0] w_avg;
    logic [13:0]                w_band;
    logic signed [DW-1:0]       w_diff;
    logic                       w_up;
    logic [DW-1:0]              w_dev, w_spread;
    logic                       w_exceed, w_still;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_sel <= SEL_BYPASS;
            r_div_size <= CFG_DIV_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_BAND_SEL: r_band_sel <= i_cfg_wdata[CFG_SEL_W-1:0];
                REG_DIV_SIZE: r_div_size <= i_cfg_wdata[CFG_DIV_W-1:0];
                default:      r_div_size <= r_div_size;
            endcase
        end
    end

    // Mode decode
    assign w_bypass = (r_band_sel == SEL_BYPASS);
    always_comb begin
        w_frozen = r_band_sel inside {[SEL_FROZEN_LO:SEL_FROZEN_HI]};
    end

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_bypass) begin
                        n_state = S_OUT;
                    end else if (!w_frozen) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_scan_cnt == CNTW'(WINDOW - 1)) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE:   n_state = S_OUT;
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        s_axis_tready     = 1'b0;
        w_cell_ctrl.load  = 1'b0;
        w_cell_ctrl.shift = 1'b0;
        w_scan_en         = 1'b0;
        w_div_start       = 1'b0;
        w_commit          = 1'b0;
        w_out_load        = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && !w_bypass && !w_frozen) begin
                    w_cell_ctrl.load  = !r_primed;
                    w_cell_ctrl.shift = r_primed;
                end
            end
            S_SCAN: begin
                w_cell_ctrl.shift = 1'b1;
                w_scan_en         = 1'b1;
            end
            S_DIV_GO:   w_div_start = 1'b1;
            S_DIV_WAIT: w_div_start = 1'b0;
            S_DECIDE:   w_commit    = 1'b1;
            S_OUT:      w_out_load  = !r_out_valid || m_axis_tready;
            default:    w_out_load  = 1'b0;
        endcase
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Cell row: new word enters at the head on accept, the row rotates while scanning
    assign w_head = (r_state == S_IDLE) ? $signed(s_axis_tdata) : w_tail;
    assign w_tail = w_cell_q[WINDOW-1];

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        if (g == 0) begin : g_first
            wmd_cell u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_cell_ctrl),
                .i_fill ($signed(s_axis_tdata)),
                .i_prev (w_head),
                .o_q    (w_cell_q[g])
            );
        end else begin : g_rest
            wmd_cell u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_cell_ctrl),
                .i_fill ($signed(s_axis_tdata)),
                .i_prev (w_cell_q[g-1]),
                .o_q    (w_cell_q[g])
            );
        end
    end

    // Scan accumulator: sum, max and min of the word leaving the tail
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
        end else if (w_scan_en) begin
            r_scan_cnt <= (r_scan_cnt == CNTW'(WINDOW - 1)) ? '0 : r_scan_cnt + 1'b1;
        end else begin
            r_scan_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan_en) begin
            if (r_scan_cnt == '0) begin
                r_sum <= SUMW'(w_tail);
                r_max <= w_tail;
                r_min <= w_tail;
            end else begin
                r_sum <= r_sum + SUMW'(w_tail);
                if (w_tail > r_max) r_max <= w_tail;
                if (w_tail < r_min) r_min <= w_tail;
            end
        end
    end

    // Window average
    wmd_divider #(
        .WINDOW (WINDOW)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (r_sum),
        .o_done  (w_div_done),
        .o_quot  (w_avg)
    );

    // Band, deviation from the lock and window spread
    assign w_band   = 14'(band16(r_band_sel)) * 14'(r_div_size);
    assign w_diff   = DW'(w_avg) - DW'(r_lock);
    assign w_up     = !w_diff[DW-1] && (w_diff != '0);
    assign w_dev    = w_up ? DW'(w_diff) : DW'(-w_diff);
    assign w_exceed = w_dev > DW'(w_band);
    assign w_spread = DW'(DW'(r_max) - DW'(r_min));
    assign w_still  = w_spread < DW'(w_band);

    // Stability decision
    always_comb begin
        n_stable = r_stable;
        n_lock   = r_lock;
        n_rise   = r_rise;
        n_fall   = r_fall;
        if (r_stable) begin
            if (!w_exceed) begin
                n_rise = ALLOW_FULL;
                n_fall = ALLOW_FULL;
            end else if (w_up) begin
                n_fall = ALLOW_FULL;
                if (r_rise != '0) n_rise = r_rise - 1'b1;
                else              n_stable = 1'b0;
            end else begin
                n_rise = ALLOW_FULL;
                if (r_fall != '0) n_fall = r_fall - 1'b1;
                else              n_stable = 1'b0;
            end
        end else if (w_still) begin
            n_stable = 1'b1;
            n_lock   = w_avg;
            n_rise   = ALLOW_FULL;
            n_fall   = ALLOW_FULL;
        end
        n_res_data = n_stable ? w_avg : r_sample;
    end

    // Detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_stable <= 1'b0;
            r_lock   <= '0;
            r_rise   <= '0;
            r_fall   <= '0;
        end else begin
            if (w_accept && !w_bypass && !w_frozen) begin
                r_primed <= 1'b1;
            end
            if (w_commit) begin
                r_stable <= n_stable;
                r_lock   <= n_lock;
                r_rise   <= n_rise;
                r_fall   <= n_fall;
            end
        end
    end

    // Pending result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample     <= s_axis_tdata;
            r_res_data   <= s_axis_tdata;
            r_res_stable <= 1'b1;
        end else if (w_commit) begin
            r_res_data   <= n_res_data;
            r_res_stable <= n_stable;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data   <= r_res_data;
            r_out_stable <= r_res_stable;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_stable;

endmodule

// ----- rtl/core/wmd_cell.sv -----
// One window cell: holds a single sample and passes it to the next cell.
// Depends on wmd_pkg.
module wmd_cell import wmd_pkg::*; (
    input  logic                       i_clk,
    input  t_cell_ctrl                 i_ctrl,
    input  logic signed [SAMPLE_W-1:0] i_fill,
    input  logic signed [SAMPLE_W-1:0] i_prev,
    output logic signed [SAMPLE_W-1:0] o_q
);

    logic signed [SAMPLE_W-1:0] r_q;

    // Fill on first sample, otherwise take the neighbor's word
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_q <= i_fill;
        end else if (i_ctrl.shift) begin
            r_q <= i_prev;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/core/wmd_divider.sv -----
// Iterative signed divide of the window sum by WINDOW, truncating toward zero.
// Restoring division, eight quotient bits per cycle. Depends on wmd_pkg.
module wmd_divider import wmd_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_start,
    input  logic signed [SAMPLE_W+$clog2(WINDOW)-1:0]   i_sum,
    output logic                                        o_done,
    output logic signed [SAMPLE_W-1:0]                  o_quot
);

    localparam int SUMW    = SAMPLE_W + $clog2(WINDOW);
    localparam int STEP_N  = 8;
    localparam int DIV_CYC = (SUMW + STEP_N - 1) / STEP_N;
    localparam int DIVW    = DIV_CYC * STEP_N;
    localparam int REMW    = $clog2(WINDOW) + 1;
    localparam int CNTW    = $clog2(DIV_CYC + 1);
    localparam logic [REMW-1:0] DIVISOR = REMW'(WINDOW);

    logic [DIVW-1:0]            r_num, n_num;
    logic [REMW-1:0]            r_rem, n_rem;
    logic [CNTW-1:0]            r_cnt;
    logic                       r_busy;
    logic                       r_neg;
    logic                       r_done;
    logic signed [SAMPLE_W-1:0] r_quot;
    logic [SUMW-1:0]            w_mag;
    logic [SAMPLE_W-1:0]        w_qmag;

    // Magnitude of the dividend
    assign w_mag = i_sum[SUMW-1] ? SUMW'(-i_sum) : SUMW'(i_sum);

    // Eight restoring steps; remainder stays below WINDOW between steps
    always_comb begin
        logic [REMW-1:0] rem;
        logic [DIVW-1:0] num;
        logic [REMW-1:0] sh;
        rem = r_rem;
        num = r_num;
        for (int k = 0; k < STEP_N; k++) begin
            sh = {rem[REMW-2:0], num[DIVW-1]};
            if (sh >= DIVISOR) begin
                rem = sh - DIVISOR;
                num = {num[DIVW-2:0], 1'b1};
            end else begin
                rem = sh;
                num = {num[DIVW-2:0], 1'b0};
            end
        end
        n_rem = rem;
        n_num = num;
    end

    assign w_qmag = r_num[SAMPLE_W-1:0];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNTW'(DIV_CYC)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= DIVW'(w_mag);
            r_rem <= '0;
            r_neg <= i_sum[SUMW-1];
        end else if (r_busy) begin
            if (r_cnt == CNTW'(DIV_CYC)) begin
                r_quot <= r_neg ? SAMPLE_W'(~w_qmag + 1'b1) : w_qmag;
            end else begin
                r_num <= n_num;
                r_rem <= n_rem;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for weight_motion_detector: streams weight samples in,
// predicts the settled weight and stable flag per sample, checks the output stream.
// Depends on rtl/core/wmd_pkg.sv and rtl/core/weight_motion_detector.sv.
module testbench;
    import wmd_pkg::*;

    localparam int WIN            = WINDOW_DEF;
    localparam int BREAKS         = BREAK_COUNT_DEF;
    localparam int RANDOM_SAMPLES = 900;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_WAIT       = 11;
    localparam int MAX_REPORTS    = 50;
    localparam int TIMEOUT_NS     = 3_000_000;

    localparam logic [CFG_SEL_W-1:0] SEL_BAND_MIN = 3'd1;
    localparam logic [CFG_SEL_W-1:0] SEL_BAND_MID = 3'd3;
    localparam logic [CFG_SEL_W-1:0] SEL_BAND_MAX = 3'd5;
    localparam logic [CFG_DIV_W-1:0] DIV_MAX      = 7'd127;

    typedef struct packed {
        logic [SAMPLE_W-1:0] weight;
        logic                stable;
    } t_settled;

    // DUT connections; the inputs driven here are known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [SAMPLE_W-1:0]   m_data;
    logic [0:0]            m_user;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Register mirror (reset values)
    logic [CFG_SEL_W-1:0]  cur_sel = SEL_BYPASS;
    logic [CFG_DIV_W-1:0]  cur_div = 7'd1;

    // Predicted detector state
    logic [SAMPLE_W-1:0]   win_buf [0:WIN-1];
    int                    win_slot   = 0;
    bit                    win_primed = 1'b0;
    bit                    is_settled = 1'b0;
    longint                lock_avg   = 0;
    int                    rise_left  = 0;
    int                    fall_left  = 0;

    // Stimulus and expectations
    logic [SAMPLE_W-1:0]   pending [$];
    t_settled              settled_q [$];
    bit                    send_idle  = 1'b0;
    bit                    recv_idle  = 1'b0;
    bit                    hold_req   = 1'b0;
    bit                    hold_taken = 1'b0;
    int                    hold_left  = 0;
    int                    send_wait  = 0;
    int                    recv_wait  = 0;

    int                    random_count  = 0;
    int                    sample_count  = 0;
    int                    result_count  = 0;
    int                    stable_count  = 0;
    int                    setting_count = 0;
    int                    err_count     = 0;

    weight_motion_detector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),     // [31:0] weight_sample
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),     // [31:0] settled_weight
        .m_axis_tuser  (m_user),     // [0] is_stable
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Motion band in weight counts: sixteenths of a division times the division size
    function automatic longint band_counts(input logic [CFG_SEL_W-1:0] sel,
                                           input logic [CFG_DIV_W-1:0] div);
        longint sixteenths;
        case (sel)
            3'd1:    sixteenths = 8;
            3'd2:    sixteenths = 16;
            3'd3:    sixteenths = 32;
            3'd4:    sixteenths = 64;
            3'd5:    sixteenths = 96;
            default: sixteenths = 0;
        endcase
        return sixteenths * longint'(div);
    endfunction

    function automatic int draw_wait(input bit enable);
        return enable ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    // Update the window and stability state for one sample, queue the settled word
    function automatic void predict_settled(input logic [SAMPLE_W-1:0] sample);
        t_settled r;
        longint   band;
        longint   hi;
        longint   lo;
        longint   total;
        longint   mean;
        longint   w;
        int       i;
        r.weight = sample;
        r.stable = 1'b1;
        if (cur_sel == SEL_BYPASS) begin
            settled_q.push_back(r);
            return;
        end
        if (cur_sel == SEL_FROZEN_LO || cur_sel == SEL_FROZEN_HI)
            return;
        band = band_counts(cur_sel, cur_div);

        // first sample after reset fills the whole window
        if (!win_primed) begin
            for (i = 0; i < WIN; i++)
                win_buf[i] = sample;
            win_primed = 1'b1;
        end
        win_buf[win_slot] = sample;
        win_slot = (win_slot + 1) % WIN;

        hi = longint'($signed(win_buf[0]));
        lo = hi;
        total = 0;
        for (i = 0; i < WIN; i++) begin
            w = longint'($signed(win_buf[i]));
            if (w > hi) hi = w;
            if (w < lo) lo = w;
            total += w;
        end
        mean = total / WIN;   // truncates toward zero

        if (is_settled) begin
            // equal average counts as the downward direction
            if (mean > lock_avg) begin
                if (mean - lock_avg > band) begin
                    fall_left = BREAKS;
                    if (rise_left != 0) rise_left = rise_left - 1;
                    else is_settled = 1'b0;
                end else begin
                    rise_left = BREAKS;
                    fall_left = BREAKS;
                end
            end else begin
                if (lock_avg - mean > band) begin
                    rise_left = BREAKS;
                    if (fall_left != 0) fall_left = fall_left - 1;
                    else is_settled = 1'b0;
                end else begin
                    rise_left = BREAKS;
                    fall_left = BREAKS;
                end
            end
        end else if (hi - lo < band) begin
            is_settled = 1'b1;
            lock_avg   = mean;
            rise_left  = BREAKS;
            fall_left  = BREAKS;
        end

        if (is_settled)
            r.weight = mean[SAMPLE_W-1:0];
        r.stable = is_settled;
        settled_q.push_back(r);
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    // Input side: one word per handshake, random gap after each accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid   <= 1'b0;
            s_data    <= '0;
            send_wait <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_wait != 0) begin
                s_valid   <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (pending.size() != 0) begin
                s_valid   <= 1'b1;
                s_data    <= pending.pop_front();
                send_wait <= draw_wait(send_idle);
            end else begin
                s_valid   <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, taken once when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
        end
    end

    // Output side: random stall after each accepted word
    always @(posedge i_clk) begin : recv_side
        int nxt;
        if (!i_rst_n) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
        end else if (m_valid && m_ready) begin
            nxt = draw_wait(recv_idle);
            recv_wait <= nxt;
            m_ready   <= (nxt == 0);
        end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
            m_ready   <= (recv_wait == 1);
        end else begin
            m_ready   <= 1'b1;
        end
    end

    // Predict on every accepted input word, check every accepted output word
    always @(posedge i_clk) begin : result_check
        t_settled want;
        if (i_rst_n) begin
            if (s_valid && s_ready) begin
                predict_settled(s_data);
                sample_count++;
            end
            if (m_valid && m_ready) begin
                if (settled_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word weight=%h stable=%b",
                                              m_data, m_user[0]));
                end else begin
                    want = settled_q.pop_front();
                    result_count++;
                    if (want.stable) stable_count++;
                    if (m_data !== want.weight)
                        report_mismatch($sformatf("settled_weight %h, expected %h",
                                                  m_data, want.weight));
                    if (m_user[0] !== want.stable)
                        report_mismatch($sformatf("is_stable %b, expected %b",
                                                  m_user[0], want.stable));
                end
            end
        end
    end

    // Wait until every word is sent and answered, then let the block go idle
    task automatic wait_quiet();
        @(negedge i_clk);
        while (pending.size() != 0 || s_valid || settled_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back edges; ends on a falling edge
    task automatic apply_setting(input logic [CFG_SEL_W-1:0] sel,
                                 input logic [CFG_DIV_W-1:0] div);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_BAND_SEL;
        i_cfg_wdata <= CFG_DATA_W'(sel);
        @(posedge i_clk);
        i_cfg_addr  <= REG_DIV_SIZE;
        i_cfg_wdata <= div;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_sel     <= sel;
        cur_div     <= div;
        setting_count++;
        @(negedge i_clk);
    endtask

    task automatic queue_repeat(input logic [SAMPLE_W-1:0] word, input int count);
        repeat (count) pending.push_back(word);
    endtask

    // One random setting followed by a few segments of samples
    task automatic run_phase(input int phase_no);
        logic [CFG_SEL_W-1:0] sel;
        logic [CFG_DIV_W-1:0] div;
        logic [SAMPLE_W-1:0]  base;
        logic [SAMPLE_W-1:0]  off;
        logic [SAMPLE_W-1:0]  word;
        longint               band;
        int                   span;
        int                   spike;
        int                   segs;
        int                   len;
        int                   kind;
        int                   s;
        int                   k;
        int                   r;
        r = $urandom_range(0, 15);
        if (phase_no == 2)
            sel = SEL_BAND_MID;        // pressure phase needs a working mode
        else if (r == 0)
            sel = SEL_BYPASS;
        else if (r == 1)
            sel = ($urandom_range(0, 1) != 0) ? SEL_FROZEN_HI : SEL_FROZEN_LO;
        else
            sel = CFG_SEL_W'($urandom_range(SEL_BAND_MIN, SEL_BAND_MAX));
        case ($urandom_range(0, 9))
            0:       div = 7'd0;
            1:       div = 7'd1;
            2:       div = DIV_MAX;
            3:       div = 7'd100;
            default: div = CFG_DIV_W'($urandom_range(1, 100));
        endcase

        wait_quiet();
        apply_setting(sel, div);
        send_idle <= ($urandom_range(0, 3) != 0);
        recv_idle <= ($urandom_range(0, 3) != 0);
        if (phase_no == 2)
            hold_req <= 1'b1;

        // frozen modes: a few words that must produce nothing
        if (sel == SEL_FROZEN_LO || sel == SEL_FROZEN_HI) begin
            repeat (4) pending.push_back($urandom());
            return;
        end

        band = band_counts(sel, div);
        span = (band > 1) ? int'(band) - 1 : 0;
        segs = (sel == SEL_BYPASS) ? 1 : $urandom_range(1, 4);
        for (s = 0; s < segs; s++) begin
            len  = $urandom_range(6, 30);
            kind = $urandom_range(0, 9);
            case ($urandom_range(0, 5))
                0:       base = 32'h7FFF_FFFF - $urandom_range(0, 20000);
                1:       base = 32'h8000_0000 + $urandom_range(0, 20000);
                2:       base = $urandom_range(0, 2000) - 1000;
                default: base = $urandom();
            endcase
            for (k = 0; k < len; k++) begin
                case (kind)
                    0: word = $urandom();                       // pure noise
                    1: word = base + k * (span + 1 + $urandom_range(0, 3 * span + 16));
                    2: word = base + $urandom_range(0, span + span / 4 + 1);
                    default: begin
                        // settling run, with an occasional spike out of the band
                        off = $urandom_range(0, span);
                        if ($urandom_range(0, 11) == 0) begin
                            spike = $urandom_range(10 * span + 10, 40 * span + 50);
                            off = ($urandom_range(0, 1) != 0) ? off + spike : off - spike;
                        end
                        word = base + off;
                    end
                endcase
                pending.push_back(word);
                random_count++;
            end
        end
    endtask

    initial begin : stimulus
        int phase_no;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bypass: sample passes through, flagged stable
        apply_setting(SEL_BYPASS, 7'd1);
        queue_repeat(32'h7FFF_FFFF, 1);
        queue_repeat(32'h8000_0000, 1);
        queue_repeat(32'h0000_0000, 1);
        queue_repeat(32'hFFFF_FFFF, 1);

        // frozen modes: no result, state kept
        wait_quiet();
        apply_setting(SEL_FROZEN_LO, 7'd1);
        queue_repeat(32'h1234_5678, 2);
        wait_quiet();
        apply_setting(SEL_FROZEN_HI, DIV_MAX);
        queue_repeat(32'hDEAD_BEEF, 1);

        // narrowest band: window fill, lock, equal average, break after two steps, relock
        wait_quiet();
        apply_setting(SEL_BAND_MIN, 7'd1);
        queue_repeat(32'd100, 2);
        queue_repeat(32'd5000, 10);

        // zero division size: the band is zero, so no window ever counts as still
        wait_quiet();
        apply_setting(SEL_BAND_MID, 7'd0);
        queue_repeat(32'd5000, 1);
        queue_repeat(32'd6000, 2);

        // widest band with full-scale samples
        wait_quiet();
        apply_setting(SEL_BAND_MAX, DIV_MAX);
        queue_repeat(32'h7FFF_FFFF, 2);
        queue_repeat(32'h8000_0000, 2);

        phase_no = 0;
        while (random_count < RANDOM_SAMPLES) begin
            run_phase(phase_no);
            phase_no++;
        end
        wait_quiet();

        $display("run covered %0d samples over %0d register settings, incl. bypass, frozen,",
                 sample_count, setting_count);
        $display("random bands, division sizes 0 and 127; %0d results (%0d stable), %0d errors",
                 result_count, stable_count, err_count);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout: results still outstanding (%0d)", settled_q.size());
        $display("status: fail");
        $finish;
    end

endmodule
